// ===== rtl/wdt_tu_pkg.sv =====
// Shared types, control register bit positions and the period helper for the watchdog.
package wdt_tu_pkg;

    localparam int CTRL_W    = 8;
    localparam int CMD_W     = 3;
    localparam int CFG_W     = 16;
    localparam int PROD_W    = 32;
    localparam int CNT_W     = 40;
    localparam int AGE_W     = 3;
    localparam int IDX_W     = 4;
    localparam int CFG_IDX_W = 1;

    // control register layout
    localparam int BIT_WDIF = 7;
    localparam int BIT_WDIE = 6;
    localparam int BIT_WDP3 = 5;
    localparam int BIT_WDCE = 4;
    localparam int BIT_WDE  = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 3'd0,
        CMD_WRITE   = 3'd1,
        CMD_READ    = 3'd2,
        CMD_RESTART = 3'd3,
        CMD_ACK     = 3'd4,
        CMD_SYSRST  = 3'd5
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLOCK_DIVIDE = 1'b0,
        CFG_BASE_DELAY   = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [CTRL_W-1:0] write_data;
        logic              reset_flag;
    } item_t;

    typedef struct packed {
        logic [CTRL_W-1:0] read_data;
        logic              irq;
        logic              reset_request;
        logic              running;
    } result_t;

    // (base*divide) << idx, saturated to 40 bits; zero counts as one
    function automatic logic [CNT_W-1:0] period_calc(input logic [PROD_W-1:0] prod,
                                                     input logic [IDX_W-1:0] idx);
        logic [PROD_W+15-1:0] wide;
        logic [CNT_W-1:0]     p;
        wide = {15'd0, prod} << idx;
        if (wide[PROD_W+15-1:CNT_W] != '0)
            p = '1;
        else
            p = wide[CNT_W-1:0];
        if (p == '0)
            p = CNT_W'(1);
        return p;
    endfunction

endpackage

// ===== rtl/wdt_tu_if.sv =====
// Request and result channel interfaces of the watchdog.
interface wdt_tu_in_if;
    logic                          valid;
    logic                          ready;
    logic [wdt_tu_pkg::CMD_W-1:0]  cmd;
    logic [wdt_tu_pkg::CTRL_W-1:0] write_data;
    logic                          reset_flag;

    modport source (output valid, cmd, write_data, reset_flag, input ready);
    modport sink   (input valid, cmd, write_data, reset_flag, output ready);
endinterface

interface wdt_tu_out_if;
    logic                          valid;
    logic                          ready;
    logic [wdt_tu_pkg::CTRL_W-1:0] read_data;
    logic                          irq;
    logic                          reset_request;
    logic                          running;

    modport source (output valid, read_data, irq, reset_request, running, input ready);
    modport sink   (input valid, read_data, irq, reset_request, running, output ready);
endinterface

// ===== rtl/watchdog_timer_timed_unlock_top.sv =====
// Top level of the watchdog timer with timed-unlock control register.
//
// Requests arrive on cmd_ch (cmd, write_data, reset_flag) with valid/ready;
// each request gives exactly one result on res_ch (read_data, irq,
// reset_request, running). A request is registered on acceptance, processed
// from the request register and its result held in an output register. One
// request per cycle is taken sustained unless res_ch stalls; the elapsed
// counter and control register update once per request. When res_ch stalls,
// the held result and the registered request stay put and cmd_ch.ready
// drops once both are full; nothing is dropped or repeated. The clock_divide
// and base_delay are written through cfg_we, cfg_index and cfg_data, by the
// user only while no request is in flight (the block does not enforce this);
// their product is registered at the write, so the period needs only a shift
// at use. Reset (rst_n low) clears the control register, the change window
// and the timer, and loads clock_divide = 125 and base_delay = 2048.
module watchdog_timer_timed_unlock_top #(
    parameter int UNLOCK_WINDOW   = 4,
    parameter int MAX_DELAY_INDEX = 9
) (
    input  logic                              clk,
    input  logic                              rst_n,
    wdt_tu_in_if.sink                         cmd_ch,
    wdt_tu_out_if.source                      res_ch,
    input  logic                              cfg_we,
    input  logic [wdt_tu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wdt_tu_pkg::CFG_W-1:0]      cfg_data
);

    logic [wdt_tu_pkg::CFG_W-1:0]  div_reg, div_next;
    logic [wdt_tu_pkg::CFG_W-1:0]  base_reg, base_next;
    logic [wdt_tu_pkg::PROD_W-1:0] prod_reg;

    logic                          v1_reg;
    wdt_tu_pkg::item_t             item_reg;
    logic                          res_valid_reg;
    wdt_tu_pkg::result_t           res_reg;
    wdt_tu_pkg::result_t           res_next;
    logic                          adv;
    logic                          in_fire;

    // configuration registers and their product
    always_comb
    begin
        div_next  = div_reg;
        base_next = base_reg;
        if (cfg_we)
        begin
            case (wdt_tu_pkg::cfg_idx_t'(cfg_index))
                wdt_tu_pkg::CFG_CLOCK_DIVIDE: div_next  = cfg_data;
                wdt_tu_pkg::CFG_BASE_DELAY:   base_next = cfg_data;
                default:                      div_next  = div_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg  <= wdt_tu_pkg::CFG_W'(125);
            base_reg <= wdt_tu_pkg::CFG_W'(2048);
            prod_reg <= wdt_tu_pkg::PROD_W'(125 * 2048);
        end
        else
        begin
            div_reg  <= div_next;
            base_reg <= base_next;
            prod_reg <= wdt_tu_pkg::PROD_W'(div_next) * wdt_tu_pkg::PROD_W'(base_next);
        end
    end

    // request register and result register
    assign adv           = v1_reg && (!res_valid_reg || res_ch.ready);
    assign cmd_ch.ready  = !v1_reg || adv;
    assign in_fire       = cmd_ch.valid && cmd_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
                v1_reg <= 1'b1;
            else if (adv)
                v1_reg <= 1'b0;
            if (adv)
                res_valid_reg <= 1'b1;
            else if (res_ch.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg.cmd        <= cmd_ch.cmd;
            item_reg.write_data <= cmd_ch.write_data;
            item_reg.reset_flag <= cmd_ch.reset_flag;
        end
        if (adv)
            res_reg <= res_next;
    end

    wdt_tu_core #(
        .UNLOCK_WINDOW   (UNLOCK_WINDOW),
        .MAX_DELAY_INDEX (MAX_DELAY_INDEX)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (adv),
        .item   (item_reg),
        .prod   (prod_reg),
        .result (res_next)
    );

    assign res_ch.valid         = res_valid_reg;
    assign res_ch.read_data     = res_reg.read_data;
    assign res_ch.irq           = res_reg.irq;
    assign res_ch.reset_request = res_reg.reset_request;
    assign res_ch.running       = res_reg.running;

endmodule

// ===== rtl/wdt_tu_core.sv =====
// Watchdog state: control register, change window, period and elapsed counter.
module wdt_tu_core #(
    parameter int UNLOCK_WINDOW   = 4,
    parameter int MAX_DELAY_INDEX = 9
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           go,
    input  wdt_tu_pkg::item_t              item,
    input  logic [wdt_tu_pkg::PROD_W-1:0]  prod,
    output wdt_tu_pkg::result_t            result
);

    localparam logic [wdt_tu_pkg::AGE_W-1:0] WIN     = wdt_tu_pkg::AGE_W'(UNLOCK_WINDOW);
    localparam logic [wdt_tu_pkg::IDX_W-1:0] IDX_MAX = wdt_tu_pkg::IDX_W'(MAX_DELAY_INDEX);

    logic [wdt_tu_pkg::CTRL_W-1:0] ctrl_reg, ctrl_next;
    logic [wdt_tu_pkg::AGE_W-1:0]  age_reg, age_next;
    logic                          open_reg, open_next;
    logic                          en_reg, en_next;
    logic [wdt_tu_pkg::CNT_W-1:0]  period_reg, period_next;
    logic [wdt_tu_pkg::CNT_W-1:0]  elapsed_reg, elapsed_next;

    logic                          cfg_do;
    logic                          cfg_en;
    logic [wdt_tu_pkg::IDX_W-1:0]  cfg_idx;
    logic [wdt_tu_pkg::IDX_W-1:0]  idx_clamp;
    logic [wdt_tu_pkg::AGE_W-1:0]  age_inc;
    logic [wdt_tu_pkg::CNT_W-1:0]  elapsed_inc;
    logic                          we;
    logic                          irq;
    logic                          rst_req;

    always_comb
    begin
        ctrl_next    = ctrl_reg;
        age_next     = age_reg;
        open_next    = open_reg;
        en_next      = en_reg;
        period_next  = period_reg;
        elapsed_next = elapsed_reg;
        cfg_do       = 1'b0;
        cfg_en       = 1'b0;
        cfg_idx      = '0;
        irq          = 1'b0;
        rst_req      = 1'b0;
        we           = 1'b0;
        age_inc      = age_reg;
        elapsed_inc  = elapsed_reg + wdt_tu_pkg::CNT_W'(1);

        case (wdt_tu_pkg::cmd_t'(item.cmd))
            wdt_tu_pkg::CMD_TICK:
            begin
                if (open_reg)
                begin
                    if (age_reg != '1)
                        age_inc = age_reg + wdt_tu_pkg::AGE_W'(1);
                    if (age_inc > WIN)
                    begin
                        open_next = 1'b0;
                        age_next  = '0;
                        ctrl_next[wdt_tu_pkg::BIT_WDCE] = 1'b0;
                    end
                    else
                    begin
                        age_next = age_inc;
                    end
                end
                if (en_reg)
                begin
                    if (elapsed_inc >= period_reg)
                    begin
                        elapsed_next = '0;
                        if (ctrl_next[wdt_tu_pkg::BIT_WDIE] && !ctrl_next[wdt_tu_pkg::BIT_WDIF])
                        begin
                            ctrl_next[wdt_tu_pkg::BIT_WDIF] = 1'b1;
                            irq = 1'b1;
                            if (ctrl_next[wdt_tu_pkg::BIT_WDE])
                            begin
                                cfg_do  = 1'b1;
                                cfg_en  = 1'b1;
                                cfg_idx = {ctrl_next[wdt_tu_pkg::BIT_WDP3], ctrl_next[2:0]};
                            end
                        end
                        else
                        begin
                            rst_req = 1'b1;
                        end
                    end
                    else
                    begin
                        elapsed_next = elapsed_inc;
                    end
                end
            end
            wdt_tu_pkg::CMD_WRITE:
            begin
                // WDIF is write-one-to-clear
                ctrl_next = {item.write_data[wdt_tu_pkg::BIT_WDIF] ? 1'b0
                                                                    : ctrl_reg[wdt_tu_pkg::BIT_WDIF],
                             item.write_data[6:0]};
                we = item.write_data[wdt_tu_pkg::BIT_WDE];
                if (item.reset_flag)
                begin
                    we = 1'b1;
                    ctrl_next[wdt_tu_pkg::BIT_WDE] = 1'b1;
                end
                if (open_reg && age_reg >= wdt_tu_pkg::AGE_W'(1) && age_reg <= WIN)
                begin
                    if (!item.write_data[wdt_tu_pkg::BIT_WDCE])
                    begin
                        cfg_do  = 1'b1;
                        cfg_en  = we | item.write_data[wdt_tu_pkg::BIT_WDIE];
                        cfg_idx = {item.write_data[wdt_tu_pkg::BIT_WDP3], item.write_data[2:0]};
                    end
                    open_next = 1'b0;
                    age_next  = '0;
                end
                else if (item.write_data[wdt_tu_pkg::BIT_WDCE] && we)
                begin
                    open_next = 1'b1;
                    age_next  = '0;
                end
            end
            wdt_tu_pkg::CMD_RESTART:
            begin
                elapsed_next = '0;
            end
            wdt_tu_pkg::CMD_ACK:
            begin
                ctrl_next[wdt_tu_pkg::BIT_WDIF] = 1'b0;
                ctrl_next[wdt_tu_pkg::BIT_WDIE] = 1'b0;
            end
            wdt_tu_pkg::CMD_SYSRST:
            begin
                ctrl_next    = '0;
                age_next     = '0;
                open_next    = 1'b0;
                en_next      = 1'b0;
                period_next  = '0;
                elapsed_next = '0;
                if (item.reset_flag)
                begin
                    ctrl_next[wdt_tu_pkg::BIT_WDE] = 1'b1;
                    cfg_do = 1'b1;
                    cfg_en = 1'b1;
                end
            end
            default:
            begin
                // read and unused codes leave the state alone
            end
        endcase

        idx_clamp = (cfg_idx > IDX_MAX) ? IDX_MAX : cfg_idx;

        if (cfg_do)
        begin
            elapsed_next = '0;
            en_next      = cfg_en;
            period_next  = cfg_en ? wdt_tu_pkg::period_calc(prod, idx_clamp) : '0;
        end

        result.read_data     = ctrl_next;
        result.irq           = irq;
        result.reset_request = rst_req;
        result.running       = en_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg    <= '0;
            age_reg     <= '0;
            open_reg    <= 1'b0;
            en_reg      <= 1'b0;
            period_reg  <= '0;
            elapsed_reg <= '0;
        end
        else if (go)
        begin
            ctrl_reg    <= ctrl_next;
            age_reg     <= age_next;
            open_reg    <= open_next;
            en_reg      <= en_next;
            period_reg  <= period_next;
            elapsed_reg <= elapsed_next;
        end
    end

endmodule
